// ===== sv/rbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfs_pkg: shared types and constants for the bulb frame serializer
// Command and segment words, the frame descriptor, timing registers.
// ----------------------------------------------------------------------------
package rbfs_pkg;

    // command word, fields in order
    typedef struct packed {
        logic [7:0]  string_select;
        logic [5:0]  bulb_address;
        logic [7:0]  brightness;
        logic [11:0] packed_color;
    } cmd_t;

    // one line segment
    typedef struct packed {
        logic       line_index;
        logic       level;
        logic [7:0] duration_us;
        logic       last_segment;
    } seg_t;

    localparam int unsigned DATA_BITS = 26;

    // classified frame: line plus the 26 data bits, MSB sent first
    typedef struct packed {
        logic                 line;
        logic [DATA_BITS-1:0] data;
    } frame_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } qhead_t;

    // timing registers
    typedef struct packed {
        logic [7:0] start_high_us;
        logic [7:0] one_low_us;
        logic [7:0] one_high_us;
        logic [7:0] zero_low_us;
        logic [7:0] zero_high_us;
        logic [7:0] end_low_us;
    } cfg_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LOW    = 3'd5;

    localparam cfg_t CFG_RESET = '{
        start_high_us: 8'd10,
        one_low_us:    8'd20,
        one_high_us:   8'd8,
        zero_low_us:   8'd10,
        zero_high_us:  8'd20,
        end_low_us:    8'd30
    };

    // queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // segment counter: 0 start high, 1..52 data, 53 closing low
    localparam int unsigned SEG_W = 6;
    localparam logic [SEG_W-1:0] SEG_FIRST = 6'd0;
    localparam logic [SEG_W-1:0] SEG_LAST  = 6'(2 * DATA_BITS + 1);

    localparam logic [7:0] MAX_LINE = 8'd1;

endpackage

// ===== sv/rbfs_front.sv =====
// ----------------------------------------------------------------------------
// rbfs_front: command intake and frame queue
// Takes command words, drops those for no line, queues frame descriptors.
// ----------------------------------------------------------------------------
module rbfs_front import rbfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  cmd_t   cmd,
    output logic   busy,
    output qhead_t head,
    input  logic   pop
);

    frame_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    logic   accept;
    logic   push;
    logic   do_pop;
    frame_t frame_in;

    assign busy   = (cnt_reg == QCNT_W'(QDEPTH));
    assign accept = start && !busy;
    assign push   = accept && (cmd.string_select <= MAX_LINE);
    assign do_pop = pop && (cnt_reg != '0);

    assign frame_in.line = cmd.string_select[0];
    assign frame_in.data = {cmd.bulb_address, cmd.brightness, cmd.packed_color};

    assign head.valid = (cnt_reg != '0);
    assign head.frame = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= frame_in;
        end
    end

endmodule

// ===== sv/rbfs_back.sv =====
// ----------------------------------------------------------------------------
// rbfs_back: frame serializer
// Walks one frame as 54 segments, one per cycle, into a registered output.
// ----------------------------------------------------------------------------
module rbfs_back import rbfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  qhead_t head,
    output logic   pop,
    output logic   seg_strobe,
    output seg_t   seg
);

    logic                 active_reg, active_next;
    logic [SEG_W-1:0]     cnt_reg, cnt_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic                 line_reg, line_next;
    logic                 strobe_reg;
    seg_t                 seg_reg;
    seg_t                 seg_cur;
    logic                 bit_cur;

    // next frame may start once the closing low is out
    assign pop = head.valid && (!active_reg || (cnt_reg == SEG_LAST));

    assign bit_cur = shift_reg[DATA_BITS-1];

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        line_next   = line_reg;
        if (pop)
        begin
            active_next = 1'b1;
            cnt_next    = SEG_FIRST;
            shift_next  = head.frame.data;
            line_next   = head.frame.line;
        end
        else if (active_reg)
        begin
            if (cnt_reg == SEG_LAST)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                // move to next bit after its high half
                if (cnt_reg != SEG_FIRST && !cnt_reg[0])
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        seg_cur.line_index   = line_reg;
        seg_cur.last_segment = 1'b0;
        priority if (cnt_reg == SEG_FIRST)
        begin
            seg_cur.level       = 1'b1;
            seg_cur.duration_us = cfg.start_high_us;
        end
        else if (cnt_reg == SEG_LAST)
        begin
            seg_cur.level        = 1'b0;
            seg_cur.duration_us  = cfg.end_low_us;
            seg_cur.last_segment = 1'b1;
        end
        else if (cnt_reg[0])
        begin
            seg_cur.level       = 1'b0;
            seg_cur.duration_us = bit_cur ? cfg.one_low_us : cfg.zero_low_us;
        end
        else
        begin
            seg_cur.level       = 1'b1;
            seg_cur.duration_us = bit_cur ? cfg.one_high_us : cfg.zero_high_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= SEG_FIRST;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        line_reg  <= line_next;
        seg_reg   <= seg_cur;
    end

    assign seg_strobe = strobe_reg;
    assign seg        = seg_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SEG_LAST)
        else $error("segment counter out of range");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && cnt_reg != SEG_LAST)
        |=> (active_reg && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("frame interrupted mid-way");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_strobe && seg.last_segment)
        |-> (!seg.level && $past(cnt_reg) == SEG_LAST))
        else $error("closing segment misplaced");

    a_pop_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && cnt_reg == SEG_LAST && head.valid) |=> (cnt_reg == SEG_FIRST))
        else $error("queued frame not started after closing low");
`endif

endmodule

// ===== sv/rgb_bulb_frame_serializer.sv =====
// ----------------------------------------------------------------------------
// rgb_bulb_frame_serializer: bulb command to one-wire frame segments
// Front intake and queue, back serializer, six timing registers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on cmd is taken at a clock edge with start high
//   and busy low. busy rises only when the two-entry frame queue is full.
//   Commands with string_select above 1 are taken and dropped, no segments.
//   Segment channel: each segment word sits on seg for one cycle with
//   seg_strobe high; the receiver cannot stall, it must take every word.
//   A frame is 54 words: start high, 26 bits as low/high pairs (address,
//   intensity, color, MSB first), closing low with last_segment set.
// Path: command queued, loaded by the serializer, first segment registered.
// Throughput: one segment per cycle within a frame. Queued frames follow
//   with no gap.
// Config: cfg_we/cfg_index/cfg_data write one timing register per edge,
//   indexes 0..5; other indexes are ignored. Write only while idle.
// Reset: rst_n asynchronous, clears queue and serializer; timing registers
//   return to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_bulb_frame_serializer import rbfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 seg_strobe,
    output seg_t                 seg
);

    cfg_t   cfg_reg, cfg_next;
    qhead_t head;
    logic   pop;

    // timing register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_HIGH: cfg_next.start_high_us = cfg_data;
                CFG_ONE_LOW:    cfg_next.one_low_us    = cfg_data;
                CFG_ONE_HIGH:   cfg_next.one_high_us   = cfg_data;
                CFG_ZERO_LOW:   cfg_next.zero_low_us   = cfg_data;
                CFG_ZERO_HIGH:  cfg_next.zero_high_us  = cfg_data;
                CFG_END_LOW:    cfg_next.end_low_us    = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // intake, line check, frame queue
    rbfs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    // segment generator, registered output
    rbfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .pop        (pop),
        .seg_strobe (seg_strobe),
        .seg        (seg)
    );

endmodule
